>>> rtl/stt_pkg.sv
`timescale 1ns / 1ps
package stt_pkg;

    localparam int LineBitsDefault   = 16;
    localparam int ColumnBitsDefault = 16;

    localparam logic [5:0] K_TEXT    = 6'd0;
    localparam logic [5:0] K_END     = 6'd1;
    localparam logic [5:0] K_IDENT   = 6'd2;
    localparam logic [5:0] K_KW_BASE = 6'd3;
    localparam logic [5:0] K_INT     = 6'd17;
    localparam logic [5:0] K_FLOAT   = 6'd18;
    localparam logic [5:0] K_STRING  = 6'd19;
    localparam logic [5:0] K_PLUS    = 6'd20;
    localparam logic [5:0] K_INC     = 6'd21;
    localparam logic [5:0] K_MINUS   = 6'd22;
    localparam logic [5:0] K_DEC     = 6'd23;
    localparam logic [5:0] K_ARROW   = 6'd24;
    localparam logic [5:0] K_STAR    = 6'd25;
    localparam logic [5:0] K_SLASH   = 6'd26;
    localparam logic [5:0] K_ASSIGN  = 6'd27;
    localparam logic [5:0] K_EQ      = 6'd28;
    localparam logic [5:0] K_NOT     = 6'd29;
    localparam logic [5:0] K_NE      = 6'd30;
    localparam logic [5:0] K_LT      = 6'd31;
    localparam logic [5:0] K_LE      = 6'd32;
    localparam logic [5:0] K_LARROW  = 6'd33;
    localparam logic [5:0] K_GT      = 6'd34;
    localparam logic [5:0] K_GE      = 6'd35;
    localparam logic [5:0] K_AND     = 6'd36;
    localparam logic [5:0] K_OR      = 6'd37;
    localparam logic [5:0] K_LPAREN  = 6'd38;
    localparam logic [5:0] K_RPAREN  = 6'd39;
    localparam logic [5:0] K_LBRACE  = 6'd40;
    localparam logic [5:0] K_RBRACE  = 6'd41;
    localparam logic [5:0] K_LBRACK  = 6'd42;
    localparam logic [5:0] K_RBRACK  = 6'd43;
    localparam logic [5:0] K_SEMI    = 6'd44;
    localparam logic [5:0] K_COLON   = 6'd45;
    localparam logic [5:0] K_COMMA   = 6'd46;
    localparam logic [5:0] K_DOT     = 6'd47;
    localparam logic [5:0] K_UNKNOWN = 6'd48;

    typedef enum logic [11:0] {
        MODE_IDLE  = 12'b000000000001,
        MODE_IDENT = 12'b000000000010,
        MODE_INT   = 12'b000000000100,
        MODE_FRAC  = 12'b000000001000,
        MODE_EXPS  = 12'b000000010000,
        MODE_EXPD  = 12'b000000100000,
        MODE_STR   = 12'b000001000000,
        MODE_ESC   = 12'b000010000000,
        MODE_OP    = 12'b000100000000,
        MODE_LCOM  = 12'b001000000000,
        MODE_BCOM  = 12'b010000000000,
        MODE_BSTAR = 12'b100000000000
    } t_mode;

    typedef struct packed {
        logic [5:0]  kind;
        logic [7:0]  text_byte;
        logic [15:0] tok_line;
        logic [15:0] tok_column;
        logic        unclosed;
        logic        last;
    } t_result;

    localparam int NumKeywords = 14;
    localparam logic [47:0] KW_TEXT [NumKeywords] = '{
        48'h0000_0000_6669, 48'h0000_6573_6c65, 48'h0065_6c69_6877,
        48'h0000_0072_6f66, 48'h0000_0000_6e69, 48'h0000_7465_656d,
        48'h0000_6863_6165, 48'h0000_0074_6e69, 48'h0074_616f_6c66,
        48'h0000_6469_6f76, 48'h6e72_7574_6572, 48'h0074_6e69_7270,
        48'h0000_0069_7061, 48'h6e65_7473_696c
    };
    localparam logic [2:0] KW_LEN [NumKeywords] = '{
        3'd2, 3'd4, 3'd5, 3'd3, 3'd2, 3'd4, 3'd4,
        3'd3, 3'd5, 3'd4, 3'd6, 3'd5, 3'd3, 3'd6
    };

    function automatic logic [5:0] ident_kind(input logic [47:0] buf_v, input logic [2:0] len);
        logic [5:0] k;
        k = K_IDENT;
        for (int i = 0; i < NumKeywords; i++) begin
            if (KW_LEN[i] == len && KW_TEXT[i] == buf_v) begin
                k = K_KW_BASE + 6'(i);
            end
        end
        return k;
    endfunction

    function automatic logic [5:0] op_single(input logic [7:0] p);
        case (p)
            "+": return K_PLUS;
            "-": return K_MINUS;
            "/": return K_SLASH;
            "=": return K_ASSIGN;
            "!": return K_NOT;
            "<": return K_LT;
            ">": return K_GT;
            default: return K_UNKNOWN;
        endcase
    endfunction

    function automatic logic [5:0] op_pair(input logic [7:0] p, input logic [7:0] b);
        if (p == "+" && b == "+") return K_INC;
        if (p == "-" && b == "-") return K_DEC;
        if (p == "-" && b == ">") return K_ARROW;
        if (p == "=" && b == "=") return K_EQ;
        if (p == "!" && b == "=") return K_NE;
        if (p == "<" && b == "=") return K_LE;
        if (p == "<" && b == "-") return K_LARROW;
        if (p == ">" && b == "=") return K_GE;
        if (p == "&" && b == "&") return K_AND;
        if (p == "|" && b == "|") return K_OR;
        return K_TEXT;
    endfunction

    function automatic logic single_kind(input logic [7:0] b, output logic [5:0] k);
        logic hit;
        hit = 1'b1;
        case (b)
            "*": k = K_STAR;
            "(": k = K_LPAREN;
            ")": k = K_RPAREN;
            "{": k = K_LBRACE;
            "}": k = K_RBRACE;
            "[": k = K_LBRACK;
            "]": k = K_RBRACK;
            ";": k = K_SEMI;
            ":": k = K_COLON;
            ",": k = K_COMMA;
            ".": k = K_DOT;
            default: begin
                k = K_UNKNOWN;
                hit = 1'b0;
            end
        endcase
        return hit;
    endfunction

endpackage

>>> rtl/stt_core.sv
`timescale 1ns / 1ps
module stt_core #(
    parameter int LINE_BITS   = stt_pkg::LineBitsDefault,
    parameter int COLUMN_BITS = stt_pkg::ColumnBitsDefault
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic [7:0]       i_byte,
    input  logic             i_end,
    output logic [1:0]       o_count,
    output stt_pkg::t_result o_res0,
    output stt_pkg::t_result o_res1
);

    stt_pkg::t_mode          r_mode, n_mode;
    logic [7:0]              r_pend, n_pend;
    logic                    r_single, n_single;
    logic [47:0]             r_kbuf, n_kbuf;
    logic [2:0]              r_ilen, n_ilen;
    logic                    r_float, n_float;
    logic [15:0]             r_tok_line, n_tok_line;
    logic [15:0]             r_tok_col, n_tok_col;
    logic [LINE_BITS-1:0]    r_line, n_line;
    logic [COLUMN_BITS-1:0]  r_col, n_col;

    stt_pkg::t_result res [2];
    logic [1:0]       cnt;
    logic             restart;
    logic             unc;
    logic [7:0]       b;
    logic [5:0]       k;
    logic [5:0]       sk;
    logic             is_alpha, is_digit, is_ws, is_opc;

    function automatic stt_pkg::t_result mk(input logic [5:0] kd, input logic [7:0] tb,
                                            input logic [15:0] ln, input logic [15:0] cl,
                                            input logic u);
        stt_pkg::t_result r;
        r.kind = kd;
        r.text_byte = tb;
        r.tok_line = ln;
        r.tok_column = cl;
        r.unclosed = u;
        r.last = 1'b0;
        return r;
    endfunction

    always_comb begin
        n_mode = r_mode;
        n_pend = r_pend;
        n_single = r_single;
        n_kbuf = r_kbuf;
        n_ilen = r_ilen;
        n_float = r_float;
        n_tok_line = r_tok_line;
        n_tok_col = r_tok_col;
        n_line = r_line;
        n_col = r_col;
        cnt = 2'd0;
        res[0] = mk(stt_pkg::K_TEXT, 8'd0, 16'd0, 16'd0, 1'b0);
        res[1] = res[0];
        restart = 1'b0;
        unc = 1'b0;
        b = i_byte;
        k = stt_pkg::K_TEXT;
        sk = stt_pkg::K_TEXT;
        is_alpha = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
        is_digit = (b >= "0" && b <= "9");
        is_ws = (b == " ") || (b >= 8'd9 && b <= 8'd13);
        is_opc = (b == "+") || (b == "-") || (b == "/") || (b == "=") || (b == "!") ||
                 (b == "<") || (b == ">") || (b == "&") || (b == "|");
        if (i_end) begin
            case (r_mode)
                stt_pkg::MODE_IDENT: begin
                    res[0] = mk(stt_pkg::ident_kind(r_kbuf, r_ilen), 8'd0, r_tok_line,
                                r_tok_col, 1'b0);
                    cnt = 2'd1;
                end
                stt_pkg::MODE_INT: begin
                    res[0] = mk(stt_pkg::K_INT, 8'd0, r_tok_line, r_tok_col, 1'b0);
                    cnt = 2'd1;
                end
                stt_pkg::MODE_FRAC, stt_pkg::MODE_EXPS, stt_pkg::MODE_EXPD: begin
                    res[0] = mk(stt_pkg::K_FLOAT, 8'd0, r_tok_line, r_tok_col, 1'b0);
                    cnt = 2'd1;
                end
                stt_pkg::MODE_STR, stt_pkg::MODE_ESC: begin
                    res[0] = mk(stt_pkg::K_STRING, 8'd0, r_tok_line, r_tok_col, 1'b1);
                    cnt = 2'd1;
                end
                stt_pkg::MODE_OP: begin
                    k = stt_pkg::op_single(r_pend);
                    res[0] = mk(k, (k == stt_pkg::K_UNKNOWN) ? r_pend : 8'd0, r_tok_line,
                                r_tok_col, 1'b0);
                    cnt = 2'd1;
                end
                stt_pkg::MODE_BCOM, stt_pkg::MODE_BSTAR: unc = 1'b1;
                default: ;
            endcase
            res[cnt[0]] = mk(stt_pkg::K_END, 8'd0, 16'(r_line), 16'(r_col), unc);
            cnt = cnt + 2'd1;
            n_mode = stt_pkg::MODE_IDLE;
            n_pend = 8'd0;
            n_single = 1'b0;
            n_kbuf = 48'd0;
            n_ilen = 3'd0;
            n_float = 1'b0;
            n_tok_line = 16'd1;
            n_tok_col = 16'd0;
            n_line = LINE_BITS'(1);
            n_col = '0;
        end else begin
            if (b == 8'h0a) begin
                if (r_line != '1) n_line = r_line + LINE_BITS'(1);
                n_col = '0;
            end else if (r_col != '1) begin
                n_col = r_col + COLUMN_BITS'(1);
            end
            case (r_mode)
                stt_pkg::MODE_IDENT: begin
                    if (is_alpha || is_digit || b == "_") begin
                        for (int i = 0; i < 6; i++) begin
                            if (r_ilen == 3'(i)) n_kbuf[8*i +: 8] = b;
                        end
                        if (r_ilen != 3'd7) n_ilen = r_ilen + 3'd1;
                        res[0] = mk(stt_pkg::K_TEXT, b, r_tok_line, r_tok_col, 1'b0);
                        cnt = 2'd1;
                    end else begin
                        res[0] = mk(stt_pkg::ident_kind(r_kbuf, r_ilen), 8'd0, r_tok_line,
                                    r_tok_col, 1'b0);
                        cnt = 2'd1;
                        restart = 1'b1;
                    end
                end
                stt_pkg::MODE_INT, stt_pkg::MODE_FRAC, stt_pkg::MODE_EXPS,
                stt_pkg::MODE_EXPD: begin
                    if (is_digit && r_mode != stt_pkg::MODE_EXPS) begin
                        res[0] = mk(stt_pkg::K_TEXT, b, r_tok_line, r_tok_col, 1'b0);
                        cnt = 2'd1;
                    end else if (r_mode == stt_pkg::MODE_EXPS &&
                                 (is_digit || b == "+" || b == "-")) begin
                        n_mode = stt_pkg::MODE_EXPD;
                        res[0] = mk(stt_pkg::K_TEXT, b, r_tok_line, r_tok_col, 1'b0);
                        cnt = 2'd1;
                    end else if (r_mode == stt_pkg::MODE_INT && b == ".") begin
                        n_mode = stt_pkg::MODE_FRAC;
                        n_float = 1'b1;
                        res[0] = mk(stt_pkg::K_TEXT, b, r_tok_line, r_tok_col, 1'b0);
                        cnt = 2'd1;
                    end else if ((r_mode == stt_pkg::MODE_INT || r_mode == stt_pkg::MODE_FRAC)
                                 && (b == "e" || b == "E")) begin
                        n_mode = stt_pkg::MODE_EXPS;
                        n_float = 1'b1;
                        res[0] = mk(stt_pkg::K_TEXT, b, r_tok_line, r_tok_col, 1'b0);
                        cnt = 2'd1;
                    end else begin
                        res[0] = mk((r_mode == stt_pkg::MODE_INT) ? stt_pkg::K_INT :
                                    stt_pkg::K_FLOAT, 8'd0, r_tok_line, r_tok_col, 1'b0);
                        cnt = 2'd1;
                        restart = 1'b1;
                    end
                end
                stt_pkg::MODE_STR: begin
                    if (b == (r_single ? 8'h27 : 8'h22)) begin
                        res[0] = mk(stt_pkg::K_STRING, 8'd0, r_tok_line, r_tok_col, 1'b0);
                        cnt = 2'd1;
                        n_mode = stt_pkg::MODE_IDLE;
                    end else if (b == 8'h5c) begin
                        n_mode = stt_pkg::MODE_ESC;
                    end else begin
                        res[0] = mk(stt_pkg::K_TEXT, b, r_tok_line, r_tok_col, 1'b0);
                        cnt = 2'd1;
                    end
                end
                stt_pkg::MODE_ESC: begin
                    if (b == "n") b = 8'h0a;
                    else if (b == "t") b = 8'h09;
                    else if (b == "r") b = 8'h0d;
                    res[0] = mk(stt_pkg::K_TEXT, b, r_tok_line, r_tok_col, 1'b0);
                    cnt = 2'd1;
                    n_mode = stt_pkg::MODE_STR;
                end
                stt_pkg::MODE_OP: begin
                    k = stt_pkg::op_pair(r_pend, b);
                    if (r_pend == "/" && b == "/") begin
                        n_mode = stt_pkg::MODE_LCOM;
                    end else if (r_pend == "/" && b == "*") begin
                        n_mode = stt_pkg::MODE_BCOM;
                    end else if (k != stt_pkg::K_TEXT) begin
                        res[0] = mk(k, 8'd0, r_tok_line, r_tok_col, 1'b0);
                        cnt = 2'd1;
                        n_mode = stt_pkg::MODE_IDLE;
                    end else begin
                        k = stt_pkg::op_single(r_pend);
                        res[0] = mk(k, (k == stt_pkg::K_UNKNOWN) ? r_pend : 8'd0, r_tok_line,
                                    r_tok_col, 1'b0);
                        cnt = 2'd1;
                        restart = 1'b1;
                    end
                end
                stt_pkg::MODE_LCOM: begin
                    if (b == 8'h0a) n_mode = stt_pkg::MODE_IDLE;
                end
                stt_pkg::MODE_BCOM: begin
                    if (b == "*") n_mode = stt_pkg::MODE_BSTAR;
                end
                stt_pkg::MODE_BSTAR: begin
                    if (b == "/") n_mode = stt_pkg::MODE_IDLE;
                    else if (b != "*") n_mode = stt_pkg::MODE_BCOM;
                end
                default: restart = 1'b1;
            endcase
            if (restart) begin
                n_mode = stt_pkg::MODE_IDLE;
                if (!is_ws) begin
                    n_tok_line = 16'(n_line);
                    n_tok_col = 16'(n_col);
                    if (is_alpha || b == "_") begin
                        n_mode = stt_pkg::MODE_IDENT;
                        n_kbuf = {40'd0, b};
                        n_ilen = 3'd1;
                        res[cnt[0]] = mk(stt_pkg::K_TEXT, b, n_tok_line, n_tok_col, 1'b0);
                    end else if (is_digit) begin
                        n_mode = stt_pkg::MODE_INT;
                        n_float = 1'b0;
                        res[cnt[0]] = mk(stt_pkg::K_TEXT, b, n_tok_line, n_tok_col, 1'b0);
                    end else if (b == 8'h22 || b == 8'h27) begin
                        n_mode = stt_pkg::MODE_STR;
                        n_single = (b == 8'h27);
                    end else if (is_opc) begin
                        n_mode = stt_pkg::MODE_OP;
                        n_pend = b;
                    end else if (stt_pkg::single_kind(b, sk)) begin
                        res[cnt[0]] = mk(sk, 8'd0, n_tok_line, n_tok_col, 1'b0);
                    end else begin
                        res[cnt[0]] = mk(stt_pkg::K_UNKNOWN, b, n_tok_line, n_tok_col, 1'b0);
                    end
                    if (!(b == 8'h22 || b == 8'h27 || is_opc)) cnt = cnt + 2'd1;
                end
            end
        end
        if (cnt == 2'd1) res[0].last = 1'b1;
        if (cnt == 2'd2) res[1].last = 1'b1;
    end

    assign o_count = cnt;
    assign o_res0  = res[0];
    assign o_res1  = res[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= stt_pkg::MODE_IDLE;
            r_pend <= 8'd0;
            r_single <= 1'b0;
            r_kbuf <= 48'd0;
            r_ilen <= 3'd0;
            r_float <= 1'b0;
            r_tok_line <= 16'd1;
            r_tok_col <= 16'd0;
            r_line <= LINE_BITS'(1);
            r_col <= '0;
        end else if (i_take) begin
            r_mode <= n_mode;
            r_pend <= n_pend;
            r_single <= n_single;
            r_kbuf <= n_kbuf;
            r_ilen <= n_ilen;
            r_float <= n_float;
            r_tok_line <= n_tok_line;
            r_tok_col <= n_tok_col;
            r_line <= n_line;
            r_col <= n_col;
        end
    end

endmodule

>>> rtl/stt_fifo.sv
`timescale 1ns / 1ps
module stt_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_push_n,
    input  stt_pkg::t_result i_d0,
    input  stt_pkg::t_result i_d1,
    input  logic             i_pop,
    output logic             o_room,
    output logic             o_valid,
    output stt_pkg::t_result o_data
);

    stt_pkg::t_result r_mem [4];
    logic [1:0]       r_wr, r_rd;
    logic [2:0]       r_count;
    logic             pop;

    assign o_valid = (r_count != 3'd0);
    assign o_room  = (r_count <= 3'd2);
    assign o_data  = r_mem[r_rd];
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) r_mem[r_wr] <= i_d0;
        if (i_push_n == 2'd2) r_mem[r_wr + 2'd1] <= i_d1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= 2'd0;
            r_rd <= 2'd0;
            r_count <= 3'd0;
        end else begin
            r_wr <= r_wr + i_push_n;
            if (pop) r_rd <= r_rd + 2'd1;
            r_count <= r_count + {1'b0, i_push_n} - {2'd0, pop};
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4) else $error("result queue overflow");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_n != 2'd0) |-> o_room) else $error("push without room");
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 3'd1 && pop && i_push_n == 2'd0) |=> !o_valid)
        else $error("queue not empty after last pop");

endmodule

>>> rtl/source_text_tokenizer.sv
`timescale 1ns / 1ps
// Tokenizer taking one source byte per request (or an end mark) and giving text
// bytes and token records on the result channel. A byte is lexed in the cycle it is
// taken; each byte yields up to two results, which drain from a four-entry result
// queue at one per cycle while i_ready is high, so input is taken every cycle while
// the queue holds two or fewer results and the sustained rate follows the results produced.
module source_text_tokenizer #(
    parameter int LINE_BITS   = stt_pkg::LineBitsDefault,
    parameter int COLUMN_BITS = stt_pkg::ColumnBitsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_input,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_kind,
    output logic [7:0]  o_text_byte,
    output logic [15:0] o_tok_line,
    output logic [15:0] o_tok_column,
    output logic        o_unclosed,
    output logic        o_last
);

    logic             take;
    logic [1:0]       count;
    stt_pkg::t_result res0, res1, head;

    assign take = i_valid && o_ready;

    stt_core #(
        .LINE_BITS  (LINE_BITS),
        .COLUMN_BITS(COLUMN_BITS)
    ) u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_take (take),
        .i_byte (i_in_byte),
        .i_end  (i_end_of_input),
        .o_count(count),
        .o_res0 (res0),
        .o_res1 (res1)
    );

    stt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push_n(take ? count : 2'd0),
        .i_d0    (res0),
        .i_d1    (res1),
        .i_pop   (i_ready),
        .o_room  (o_ready),
        .o_valid (o_valid),
        .o_data  (head)
    );

    assign o_kind       = head.kind;
    assign o_text_byte  = head.text_byte;
    assign o_tok_line   = head.tok_line;
    assign o_tok_column = head.tok_column;
    assign o_unclosed   = head.unclosed;
    assign o_last       = head.last;

endmodule
